// ----- sv/lome_pkg.sv -----
package lome_pkg;

    localparam int FIELD_W        = 11;
    localparam int MAX_BOXES_DEF  = 1024;

    localparam logic [FIELD_W-1:0] BOX_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_REBUILD    = 2'd0,
        FUNC_MOVE_LEFT  = 2'd1,
        FUNC_MOVE_RIGHT = 2'd2,
        FUNC_QUERY      = 2'd3
    } func_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

// ----- sv/linked_order_move_engine.sv -----
// Box ordering engine: boxes 1..n kept as a doubly linked list in two link
// memories, with head sentinel 0 and tail sentinel n+1 (n = box_count, capped
// at MAX_BOXES). Command channel (cmd_valid/cmd_ready) carries func, moved_box
// and anchor_box; response channel (rsp_valid/rsp_ready) returns status,
// prev_box and next_box, one response transaction per command. box_count
// must be written through cfg_wr_en/cfg_wr_data only while the engine idles;
// keeping to this is left to the user. One command is processed at a time;
// cmd_ready is high only when idle. One sequencer steps the simple dual-port
// link memories (one read and one write per memory per cycle): an operand
// error goes straight to the response; a query reads x's links; a move reads
// x, splices it out, reads the anchor's neighbor and links x in beside it; a
// rebuild writes entries 0..n+1, one entry of each memory written per cycle.
// The engine returns to idle, and can accept the next command, in the cycle
// after the response is loaded. The response register frees the sequencer; a
// new command is accepted while a response waits. If the response register
// is still full when the next command finishes, the sequencer holds until
// rsp_ready takes the old one. Reset clears control state and sets box_count
// to 1024; the link memories are undefined until the first rebuild.
module linked_order_move_engine #(
    parameter int MAX_BOXES = lome_pkg::MAX_BOXES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lome_pkg::FIELD_W-1:0]  cfg_wr_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  lome_pkg::func_t               func,
    input  logic [lome_pkg::FIELD_W-1:0]  moved_box,
    input  logic [lome_pkg::FIELD_W-1:0]  anchor_box,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          status,
    output logic [lome_pkg::FIELD_W-1:0]  prev_box,
    output logic [lome_pkg::FIELD_W-1:0]  next_box
);
    import lome_pkg::*;

    localparam int DEPTH = MAX_BOXES + 2;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VW    = (IDX_W > FIELD_W) ? IDX_W : FIELD_W + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SWEEP  = 8'b0000_0010,
        S_RD_X   = 8'b0000_0100,
        S_UNLINK = 8'b0000_1000,
        S_RD_Y   = 8'b0001_0000,
        S_LINK_A = 8'b0010_0000,
        S_LINK_B = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [FIELD_W-1:0] link_to_field(input logic [IDX_W-1:0] v);
        logic [VW-1:0] w;
        w = VW'(v);
        return w[FIELD_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [FIELD_W-1:0]   box_count_reg;
    func_t                func_reg, func_next;
    logic [FIELD_W-1:0]   x_reg, x_next;
    logic [FIELD_W-1:0]   y_reg, y_next;
    logic [VW-1:0]        sweep_reg, sweep_next;
    logic                 res_status_reg, res_status_next;
    logic [FIELD_W-1:0]   res_prev_reg, res_prev_next;
    logic [FIELD_W-1:0]   res_next_reg, res_next_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 status_reg;
    logic [FIELD_W-1:0]   prev_box_reg;
    logic [FIELD_W-1:0]   next_box_reg;
    logic                 rsp_load;

    logic [VW-1:0]        n_v;
    logic [VW-1:0]        mx_v, my_v, sw_inc, sw_dec;
    logic                 cx_ok, cy_ok;
    logic [IDX_W-1:0]     xi, yi, link_a;

    logic [IDX_W-1:0]     prev_mem [DEPTH];
    logic [IDX_W-1:0]     next_mem [DEPTH];
    logic                 prev_we, next_we, prev_re, next_re;
    logic [IDX_W-1:0]     prev_waddr, next_waddr, prev_wdata, next_wdata;
    logic [IDX_W-1:0]     prev_raddr, next_raddr;
    logic [IDX_W-1:0]     prev_rd_reg, next_rd_reg;

    // Clamp the count to what the memories hold.
    assign n_v   = (VW'(box_count_reg) > VW'(MAX_BOXES)) ? VW'(MAX_BOXES)
                                                         : VW'(box_count_reg);
    assign mx_v  = VW'(moved_box);
    assign my_v  = VW'(anchor_box);
    assign cx_ok = (mx_v != '0) && (mx_v <= n_v);
    assign cy_ok = (my_v != '0) && (my_v <= n_v);

    logic [VW-1:0] xr_v, yr_v;
    assign xr_v = VW'(x_reg);
    assign yr_v = VW'(y_reg);
    assign xi   = xr_v[IDX_W-1:0];
    assign yi   = yr_v[IDX_W-1:0];

    assign sw_inc = sweep_reg + VW'(1);
    assign sw_dec = sweep_reg - VW'(1);

    assign link_a = (func_reg == FUNC_MOVE_LEFT) ? prev_rd_reg : next_rd_reg;

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_prev_next   = res_prev_reg;
        res_next_next   = res_next_reg;
        prev_we         = 1'b0;
        next_we         = 1'b0;
        prev_re         = 1'b0;
        next_re         = 1'b0;
        prev_waddr      = '0;
        next_waddr      = '0;
        prev_wdata      = '0;
        next_wdata      = '0;
        prev_raddr      = xi;
        next_raddr      = xi;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next       = func;
                    x_next          = moved_box;
                    y_next          = anchor_box;
                    sweep_next      = '0;
                    res_status_next = STATUS_ERR;
                    res_prev_next   = '0;
                    res_next_next   = '0;
                    case (func)
                        FUNC_REBUILD:
                        begin
                            res_status_next = STATUS_OK;
                            if (cx_ok)
                            begin
                                res_prev_next = moved_box - FIELD_W'(1);
                                res_next_next = moved_box + FIELD_W'(1);
                            end
                            state_next = S_SWEEP;
                        end
                        FUNC_QUERY:
                            state_next = cx_ok ? S_RD_X : S_DONE;
                        default:
                            state_next = (cx_ok && cy_ok && (moved_box != anchor_box))
                                         ? S_RD_X : S_DONE;
                    endcase
                end
            end
            S_SWEEP:
            begin
                // Write identity links, one entry per cycle, head to tail.
                prev_we    = 1'b1;
                next_we    = 1'b1;
                prev_waddr = sweep_reg[IDX_W-1:0];
                next_waddr = sweep_reg[IDX_W-1:0];
                prev_wdata = (sweep_reg == '0) ? '0 : sw_dec[IDX_W-1:0];
                if (sweep_reg == n_v + VW'(1))
                begin
                    next_wdata = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    next_wdata = sw_inc[IDX_W-1:0];
                    sweep_next = sw_inc;
                end
            end
            S_RD_X:
            begin
                prev_re    = 1'b1;
                next_re    = 1'b1;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                if (func_reg == FUNC_QUERY)
                begin
                    res_status_next = STATUS_OK;
                    res_prev_next   = link_to_field(prev_rd_reg);
                    res_next_next   = link_to_field(next_rd_reg);
                    state_next      = S_DONE;
                end
                else
                begin
                    // Splice x out: next[p] = q, prev[q] = p.
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg;
                    next_wdata = next_rd_reg;
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_reg;
                    prev_wdata = prev_rd_reg;
                    state_next = S_RD_Y;
                end
            end
            S_RD_Y:
            begin
                // Read the anchor's neighbor after the splice has landed.
                prev_raddr = yi;
                next_raddr = yi;
                if (func_reg == FUNC_MOVE_LEFT)
                    prev_re = 1'b1;
                else
                    next_re = 1'b1;
                state_next = S_LINK_A;
            end
            S_LINK_A:
            begin
                prev_we = 1'b1;
                next_we = 1'b1;
                if (func_reg == FUNC_MOVE_LEFT)
                begin
                    next_waddr    = link_a;
                    next_wdata    = xi;
                    prev_waddr    = xi;
                    prev_wdata    = link_a;
                    res_prev_next = link_to_field(link_a);
                end
                else
                begin
                    prev_waddr    = link_a;
                    prev_wdata    = xi;
                    next_waddr    = xi;
                    next_wdata    = link_a;
                    res_next_next = link_to_field(link_a);
                end
                state_next = S_LINK_B;
            end
            S_LINK_B:
            begin
                prev_we         = 1'b1;
                next_we         = 1'b1;
                res_status_next = STATUS_OK;
                if (func_reg == FUNC_MOVE_LEFT)
                begin
                    prev_waddr    = yi;
                    prev_wdata    = xi;
                    next_waddr    = xi;
                    next_wdata    = yi;
                    res_next_next = y_reg;
                end
                else
                begin
                    prev_waddr    = xi;
                    prev_wdata    = yi;
                    next_waddr    = yi;
                    next_wdata    = xi;
                    res_prev_next = y_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the response register is free.
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= BOX_COUNT_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                box_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        sweep_reg      <= sweep_next;
        res_status_reg <= res_status_next;
        res_prev_reg   <= res_prev_next;
        res_next_reg   <= res_next_next;
        if (rsp_load)
        begin
            status_reg   <= res_status_reg;
            prev_box_reg <= res_prev_reg;
            next_box_reg <= res_next_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (prev_re)
            prev_rd_reg <= prev_mem[prev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (next_re)
            next_rd_reg <= next_mem[next_raddr];
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign prev_box  = prev_box_reg;
    assign next_box  = next_box_reg;

endmodule

// ----- sv/lome_checker.sv -----
module lome_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          status,
    input logic [lome_pkg::FIELD_W-1:0]  prev_box,
    input logic [lome_pkg::FIELD_W-1:0]  next_box
);
    import lome_pkg::*;

    // A response held under backpressure keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
                                    && $stable(prev_box) && $stable(next_box))
        else $error("response changed while stalled");

    // A command transaction leaves the engine busy in the following cycle.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("engine ready right after accepting a command");

    // A rejected command reports no neighbors.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_ERR) |-> (prev_box == '0) && (next_box == '0))
        else $error("error response with nonzero links");

    // A new response only comes out of a busy sequencer.
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_ready))
        else $error("response appeared while engine was idle");

endmodule

bind linked_order_move_engine lome_checker u_lome_checker (.*);

// ----- sim/linked_order_move_engine_tb.sv -----
import lome_pkg::*;

typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] prev_id;
    logic [FIELD_W-1:0] next_id;
} neighbour_rsp_t;

class link_order_scoreboard;
    localparam int TABLE_DEPTH = MAX_BOXES_DEF + 2;

    logic [FIELD_W-1:0] prev_tab [0:TABLE_DEPTH-1];
    logic [FIELD_W-1:0] next_tab [0:TABLE_DEPTH-1];
    int                 box_count_reg;
    int                 built_top;
    neighbour_rsp_t     expected_q [$];
    int                 error_count;

    function new();
        box_count_reg = MAX_BOXES_DEF;
        built_top     = -1;
        error_count   = 0;
    endfunction

    function int used_count();
        return (box_count_reg > MAX_BOXES_DEF) ? MAX_BOXES_DEF : box_count_reg;
    endfunction

    function void set_count(int v);
        box_count_reg = v & 'h7FF;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // True when the command would read a link entry that no rebuild has written.
    function bit reads_unbuilt(func_t f, int x, int y);
        int n;
        bit x_ok;
        bit y_ok;
        n    = used_count();
        x_ok = (x >= 1 && x <= n);
        y_ok = (y >= 1 && y <= n);
        if (f == FUNC_REBUILD)
            return 1'b0;
        if (f == FUNC_QUERY)
            return x_ok && (x > built_top);
        if (!x_ok || !y_ok || x == y)
            return 1'b0;
        return (x > built_top) || (y > built_top);
    endfunction

    function void note_cmd(func_t f, int x, int y);
        int             n;
        bit             x_ok;
        bit             y_ok;
        int             p;
        int             q;
        int             a;
        neighbour_rsp_t r;
        n    = used_count();
        x_ok = (x >= 1 && x <= n);
        y_ok = (y >= 1 && y <= n);
        r    = '0;
        case (f)
            FUNC_REBUILD:
            begin
                for (int i = 0; i <= n + 1; i++)
                begin
                    prev_tab[i] = (i == 0) ? '0 : FIELD_W'(i - 1);
                    next_tab[i] = (i == n + 1) ? '0 : FIELD_W'(i + 1);
                end
                if (built_top < n + 1)
                    built_top = n + 1;
                if (x_ok)
                begin
                    r.prev_id = FIELD_W'(x - 1);
                    r.next_id = FIELD_W'(x + 1);
                end
            end
            FUNC_QUERY:
            begin
                if (x_ok)
                begin
                    r.prev_id = prev_tab[x];
                    r.next_id = next_tab[x];
                end
                else
                begin
                    r.status = STATUS_ERR;
                end
            end
            default:
            begin
                if (!x_ok || !y_ok || x == y)
                begin
                    r.status = STATUS_ERR;
                end
                else
                begin
                    // unlink x, then splice it in beside y
                    p = prev_tab[x];
                    q = next_tab[x];
                    next_tab[p] = FIELD_W'(q);
                    prev_tab[q] = FIELD_W'(p);
                    if (f == FUNC_MOVE_LEFT)
                    begin
                        a = prev_tab[y];
                        next_tab[a] = FIELD_W'(x);
                        prev_tab[x] = FIELD_W'(a);
                        prev_tab[y] = FIELD_W'(x);
                        next_tab[x] = FIELD_W'(y);
                    end
                    else
                    begin
                        a = next_tab[y];
                        prev_tab[a] = FIELD_W'(x);
                        next_tab[x] = FIELD_W'(a);
                        prev_tab[x] = FIELD_W'(y);
                        next_tab[y] = FIELD_W'(x);
                    end
                    r.prev_id = prev_tab[x];
                    r.next_id = next_tab[x];
                end
            end
        endcase
        expected_q.push_back(r);
    endfunction

    function void check_rsp(logic st, logic [FIELD_W-1:0] pv, logic [FIELD_W-1:0] nx);
        neighbour_rsp_t e;
        if (expected_q.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected response: status %0d prev %0d next %0d", st, pv, nx);
            return;
        end
        e = expected_q.pop_front();
        if (st !== e.status || pv !== e.prev_id || nx !== e.next_id)
        begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch: expected status %0d prev %0d next %0d,",
                         e.status, e.prev_id, e.next_id,
                         " got status %0d prev %0d next %0d", st, pv, nx);
        end
    endfunction
endclass

module linked_order_move_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 9;
    localparam int LONG_HOLD_PHASE = 6;
    localparam int LONG_HOLD       = 80;
    localparam int STALL_LIMIT     = 5000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0] cfg_wr_data = '0;
    logic               cmd_valid   = 1'b0;
    logic               cmd_ready;
    func_t              func        = FUNC_REBUILD;
    logic [FIELD_W-1:0] moved_box   = '0;
    logic [FIELD_W-1:0] anchor_box  = '0;
    logic               rsp_valid;
    logic               rsp_ready   = 1'b0;
    logic               status;
    logic [FIELD_W-1:0] prev_box;
    logic [FIELD_W-1:0] next_box;

    link_order_scoreboard sb;
    bit idle_on        = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int phase_count   [PHASES] = '{0, 1, 2047, 2, 6, 4, 16, 1024, 9};
    int phase_items   [PHASES] = '{20, 20, 60, 40, 90, 40, 110, 50, 100};
    bit phase_rebuild [PHASES] = '{1, 1, 1, 1, 1, 0, 0, 0, 1};

    linked_order_move_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .func        (func),
        .moved_box   (moved_box),
        .anchor_box  (anchor_box),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .prev_box    (prev_box),
        .next_box    (next_box)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response side: check each transaction, stall in short bursts or one long hold
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_rsp(status, prev_box, next_box);
            if (hold_left == 0)
            begin
                if (long_hold_req && !long_hold_done)
                begin
                    hold_left      = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
                else if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    hold_left = $urandom_range(1, 4);
                end
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("linked_order_move_engine_tb: FAIL");
            $finish;
        end
    end

    task automatic send_cmd(func_t f, int x, int y);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        func       <= f;
        moved_box  <= x[FIELD_W-1:0];
        anchor_box <= y[FIELD_W-1:0];
        do @(posedge clk); while (!cmd_ready);
        sb.note_cmd(f, x & 'h7FF, y & 'h7FF);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[FIELD_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic int pick_box(int n);
        int top;
        top = (n == 0) ? 1 : n;
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return n + 1;
            2:       return n;
            3:       return $urandom_range(0, 2047);
            default: return $urandom_range(1, top);
        endcase
    endfunction

    task automatic run_random(int items);
        int    n;
        int    r;
        int    x;
        int    y;
        func_t f;
        repeat (items)
        begin
            n = sb.used_count();
            r = $urandom_range(0, 99);
            // keep full-size rebuilds rare, they write one entry per cycle
            if (r < ((n > 64) ? 1 : 5))
                f = FUNC_REBUILD;
            else if (r < 40)
                f = FUNC_MOVE_LEFT;
            else if (r < 75)
                f = FUNC_MOVE_RIGHT;
            else
                f = FUNC_QUERY;
            x = pick_box(n);
            case ($urandom_range(0, 5))
                0:       y = x;
                1:       y = (x + 1) & 'h7FF;
                2:       y = (x - 1) & 'h7FF;
                default: y = pick_box(n);
            endcase
            if (sb.reads_unbuilt(f, x, y))
                f = FUNC_REBUILD;
            send_cmd(f, x, y);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_count(8);
        send_cmd(FUNC_REBUILD, 3, 0);
        send_cmd(FUNC_REBUILD, 0, 2047);
        send_cmd(FUNC_REBUILD, 9, 5);
        send_cmd(FUNC_QUERY, 1, 0);
        send_cmd(FUNC_QUERY, 8, 0);
        send_cmd(FUNC_QUERY, 0, 0);
        send_cmd(FUNC_QUERY, 9, 0);
        send_cmd(FUNC_QUERY, 2047, 2047);
        send_cmd(FUNC_MOVE_LEFT, 1, 8);
        send_cmd(FUNC_MOVE_RIGHT, 8, 1);
        send_cmd(FUNC_MOVE_LEFT, 4, 5);
        send_cmd(FUNC_MOVE_LEFT, 3, 3);
        send_cmd(FUNC_MOVE_RIGHT, 0, 4);
        send_cmd(FUNC_MOVE_LEFT, 5, 9);
        send_cmd(FUNC_MOVE_RIGHT, 2047, 1);
        send_cmd(FUNC_MOVE_LEFT, 6, 2047);
        send_cmd(FUNC_MOVE_RIGHT, 2, 7);
        send_cmd(FUNC_MOVE_LEFT, 7, 3);
        send_cmd(FUNC_QUERY, 2, 0);
        send_cmd(FUNC_MOVE_RIGHT, 1024, 1);
        send_cmd(FUNC_MOVE_LEFT, 1, 1365);
        send_cmd(FUNC_QUERY, 1, 0);
        send_cmd(FUNC_REBUILD, 8, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            write_count(phase_count[ph]);
            if (phase_rebuild[ph])
                send_cmd(FUNC_REBUILD, $urandom_range(0, 1025), $urandom_range(0, 2047));
            if (ph == LONG_HOLD_PHASE)
                long_hold_req = 1'b1;
            run_random(phase_items[ph]);
        end

        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("linked_order_move_engine_tb: PASS");
        else
            $display("linked_order_move_engine_tb: FAIL");
        $finish;
    end
endmodule
